// File: rtl/electronic_fuse_trip_retry_top_assert.svh
// assertion macros for the electronic fuse block
// each macro expands to a concurrent assertion, or to nothing in synthesis
`ifndef ELECTRONIC_FUSE_TRIP_RETRY_TOP_ASSERT_SVH
`define ELECTRONIC_FUSE_TRIP_RETRY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define EFTR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eftr assertion failed");
`define EFTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eftr assertion failed");
`else
`define EFTR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define EFTR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/eftr_pkg.sv
// shared types and constants of the electronic fuse trip and retry block
// no dependencies
`default_nettype none
package eftr_pkg;
   localparam int NUM_DRIVERS         = 4;
   localparam int CHANNELS_PER_DRIVER = 4;
   localparam int DRV_IDX_W = (NUM_DRIVERS > 1) ? $clog2(NUM_DRIVERS) : 1;
   localparam int CH_IDX_W  = (CHANNELS_PER_DRIVER > 1) ? $clog2(CHANNELS_PER_DRIVER) : 1;

   localparam int MV_W    = 12;
   localparam int DELAY_W = 16;
   localparam int PROD_W  = 24;
   localparam int ADC_SHIFT = 12;
   localparam logic [MV_W-1:0]    VREF_MV  = 12'd3300;
   localparam logic [MV_W:0]      ADC_FULL = 13'd4095;
   localparam logic [7:0]         CMD_BASE = 8'h80;
   localparam logic [DELAY_W-1:0] TICK_MAX = 16'hFFFF;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd5000;
   localparam logic [MV_W-1:0]    THR_RESET [4] = '{12'd200, 12'd200, 12'd300, 12'd500};

   // request kinds
   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_TICK   = 2'd1;
   localparam logic [1:0] REQ_SCAN   = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_CH0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_CH1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_CH2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_CH3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY   = 3'd4;

   typedef struct packed {
      logic                 capture;     // latch sample fields, start multiply
      logic                 tick;        // advance timer
      logic                 arm;         // scan complete
      logic                 convert;     // store millivolts, trip update
      logic                 load_trip;   // trip command into output register
      logic                 load_retry;  // retry command into output register
      logic [DRV_IDX_W-1:0] retry_drv;
      logic                 retry_last;
   } eftr_cmd_type;

   typedef struct packed {
      logic out_free;
      logic sample_ok;
      logic tick_fire;
      logic trip_hit;
   } eftr_status_type;
endpackage
`default_nettype wire

// File: rtl/electronic_fuse_trip_retry_top.sv
// Electronic fuse with trip and timed auto-retry for 4 drivers of 4 channels. A tick or
// scan-complete transaction is handled in the idle state. A sample takes a registered
// 12x12 multiply, then the divide-by-4095 correction, store and threshold compare. A
// sample that trips then passes through the trip state, which places the trip command in
// the output register once that register is free. A retry expiry issues one command per
// driver, 4 in all, one command per cycle as long as the output register drains. The
// output register lets a command wait while the next transaction is taken. Configuration
// writes are always accepted; stored readings reset to zero with no clearing pass.
// top level; depends on eftr_pkg, eftr_ctrl, eftr_dp and the assertion macro header
`default_nettype none
`include "electronic_fuse_trip_retry_top_assert.svh"
module electronic_fuse_trip_retry_top import eftr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [15:0]          req_tdata,  // driver_index, channel_index, raw_sample
   input  wire logic [1:0]           req_tuser,  // req_type
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,  // cmd_driver, cmd_byte, zero pad
   output logic                      rsp_tuser,  // is_retry
   output logic                      rsp_tlast,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DELAY_W-1:0]   csr_data
);
   eftr_cmd_type    cmd;
   eftr_status_type status;
   logic [1:0]      rsp_driver;
   logic [7:0]      rsp_byte;

   assign csr_ready = 1'b1;

   eftr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   eftr_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .driver_index  (req_tdata[1:0]),
      .channel_index (req_tdata[3:2]),
      .raw_sample    (req_tdata[15:4]),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_driver    (rsp_driver),
      .rsp_byte      (rsp_byte),
      .rsp_retry     (rsp_tuser),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, rsp_byte, rsp_driver};

   // a trip command always ends its transaction
   `EFTR_ASSERT_IMPL(a_trip_is_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast)
   // the marked retry command addresses the last driver
   `EFTR_ASSERT_IMPL(a_retry_last_drv, clock, reset, rsp_tvalid && rsp_tuser && rsp_tlast,
      rsp_tdata[1:0] == 2'(NUM_DRIVERS - 1))
   // every command is an output register write with the upper mask bits clear
   `EFTR_ASSERT_IMPL(a_cmd_form, clock, reset, rsp_tvalid,
      rsp_tdata[9] && (rsp_tdata[8:6] == 3'd0))
   // a tick that fires the retry is followed by the first retry command stage
   `EFTR_ASSERT_NEXT(a_retry_start, clock, reset, cmd.tick && status.tick_fire,
      !req_tready)
endmodule
`default_nettype wire

// File: rtl/eftr_dp.sv
// datapath: thresholds, stored readings, enable masks, retry timer, output register
// depends on eftr_pkg
`default_nettype none
module eftr_dp import eftr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire eftr_cmd_type         cmd,
   output eftr_status_type           status,
   input  wire logic [1:0]           driver_index,
   input  wire logic [1:0]           channel_index,
   input  wire logic [MV_W-1:0]      raw_sample,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DELAY_W-1:0]   csr_data,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_driver,
   output logic [7:0]                rsp_byte,
   output logic                      rsp_retry,
   output logic                      rsp_last
);
   logic [MV_W-1:0]    thr_ff [4];
   logic [MV_W-1:0]    thr_in [4];
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [MV_W-1:0]    stored_ff [NUM_DRIVERS][CHANNELS_PER_DRIVER];
   logic [MV_W-1:0]    stored_in [NUM_DRIVERS][CHANNELS_PER_DRIVER];
   logic [CHANNELS_PER_DRIVER-1:0] mask_ff [NUM_DRIVERS];
   logic [CHANNELS_PER_DRIVER-1:0] mask_in [NUM_DRIVERS];
   logic               armed_ff, armed_in;
   logic               pending_ff, pending_in;
   logic [DELAY_W-1:0] ticks_ff, ticks_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DRV_IDX_W-1:0] drv_ff, drv_in;
   logic [CH_IDX_W-1:0]  ch_ff, ch_in;
   logic [1:0]         thr_sel_ff, thr_sel_in;
   logic               rvalid_ff, rvalid_in;
   logic [1:0]         rdrv_ff, rdrv_in;
   logic [7:0]         rbyte_ff, rbyte_in;
   logic               rretry_ff, rretry_in;
   logic               rlast_ff, rlast_in;

   logic [MV_W-1:0]    q0;
   logic [MV_W:0]      rem;
   logic [MV_W-1:0]    mv;
   logic [DELAY_W-1:0] ticks_inc;
   logic [CHANNELS_PER_DRIVER-1:0] ok_bits;
   logic [CHANNELS_PER_DRIVER-1:0] retry_mask;
   logic [CHANNELS_PER_DRIVER-1:0] trip_mask;

   // divide by 4095: estimate by shift, then one correction step
   assign q0  = prod_ff[PROD_W-1:ADC_SHIFT];
   assign rem = {1'b0, prod_ff[ADC_SHIFT-1:0]} + {1'b0, q0};
   assign mv  = (rem >= ADC_FULL) ? q0 + 12'd1 : q0;

   assign ticks_inc = (ticks_ff == TICK_MAX) ? ticks_ff : ticks_ff + 16'd1;

   always_comb begin
      for (int c = 0; c < CHANNELS_PER_DRIVER; c++) begin
         ok_bits[c] = (stored_ff[cmd.retry_drv][c] <= thr_ff[c]);
      end
   end
   assign retry_mask = mask_ff[cmd.retry_drv] | ok_bits;
   assign trip_mask  = mask_ff[drv_ff] & ~(CHANNELS_PER_DRIVER'(1) << ch_ff);

   assign status.out_free  = !rvalid_ff || rsp_ready;
   assign status.sample_ok = (int'(driver_index) < NUM_DRIVERS)
                          && (int'(channel_index) < CHANNELS_PER_DRIVER);
   assign status.tick_fire = pending_ff && (ticks_inc >= delay_ff);
   assign status.trip_hit  = armed_ff && (mv > thr_ff[thr_sel_ff]);

   always_comb begin
      thr_in     = thr_ff;
      delay_in   = delay_ff;
      stored_in  = stored_ff;
      mask_in    = mask_ff;
      armed_in   = armed_ff;
      pending_in = pending_ff;
      ticks_in   = ticks_ff;
      prod_in    = prod_ff;
      drv_in     = drv_ff;
      ch_in      = ch_ff;
      thr_sel_in = thr_sel_ff;
      rvalid_in  = rvalid_ff && !rsp_ready;
      rdrv_in    = rdrv_ff;
      rbyte_in   = rbyte_ff;
      rretry_in  = rretry_ff;
      rlast_in   = rlast_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_THR_CH0: thr_in[0] = csr_data[MV_W-1:0];
            CSR_THR_CH1: thr_in[1] = csr_data[MV_W-1:0];
            CSR_THR_CH2: thr_in[2] = csr_data[MV_W-1:0];
            CSR_THR_CH3: thr_in[3] = csr_data[MV_W-1:0];
            CSR_DELAY:   delay_in  = csr_data;
            default: ;
         endcase
      end

      if (cmd.capture) begin
         prod_in    = PROD_W'(raw_sample) * PROD_W'(VREF_MV);
         drv_in     = DRV_IDX_W'(driver_index);
         ch_in      = CH_IDX_W'(channel_index);
         thr_sel_in = channel_index;
      end
      if (cmd.arm) begin
         armed_in = 1'b1;
      end
      if (cmd.tick) begin
         ticks_in = ticks_inc;
         if (status.tick_fire) begin
            pending_in = 1'b0;
         end
      end
      if (cmd.convert) begin
         stored_in[drv_ff][ch_ff] = mv;
         if (status.trip_hit) begin
            mask_in[drv_ff] = trip_mask;
            pending_in      = 1'b1;
            ticks_in        = '0;
         end
      end
      if (cmd.load_trip) begin
         rvalid_in = 1'b1;
         rdrv_in   = 2'(drv_ff);
         rbyte_in  = CMD_BASE | 8'(mask_ff[drv_ff]);
         rretry_in = 1'b0;
         rlast_in  = 1'b1;
      end
      if (cmd.load_retry) begin
         mask_in[cmd.retry_drv] = retry_mask;
         rvalid_in = 1'b1;
         rdrv_in   = 2'(cmd.retry_drv);
         rbyte_in  = CMD_BASE | 8'(retry_mask);
         rretry_in = 1'b1;
         rlast_in  = cmd.retry_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= THR_RESET;
         delay_ff   <= DELAY_RESET;
         armed_ff   <= 1'b0;
         pending_ff <= 1'b0;
         ticks_ff   <= '0;
         rvalid_ff  <= 1'b0;
         for (int d = 0; d < NUM_DRIVERS; d++) begin
            mask_ff[d] <= '1;
            for (int c = 0; c < CHANNELS_PER_DRIVER; c++) begin
               stored_ff[d][c] <= '0;
            end
         end
      end else begin
         thr_ff     <= thr_in;
         delay_ff   <= delay_in;
         stored_ff  <= stored_in;
         mask_ff    <= mask_in;
         armed_ff   <= armed_in;
         pending_ff <= pending_in;
         ticks_ff   <= ticks_in;
         rvalid_ff  <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      drv_ff     <= drv_in;
      ch_ff      <= ch_in;
      thr_sel_ff <= thr_sel_in;
      rdrv_ff    <= rdrv_in;
      rbyte_ff   <= rbyte_in;
      rretry_ff  <= rretry_in;
      rlast_ff   <= rlast_in;
   end

   assign rsp_valid  = rvalid_ff;
   assign rsp_driver = rdrv_ff;
   assign rsp_byte   = rbyte_ff;
   assign rsp_retry  = rretry_ff;
   assign rsp_last   = rlast_ff;
endmodule
`default_nettype wire

// File: rtl/eftr_ctrl.sv
// controller: sequences sample conversion, trip command and retry sweep
// depends on eftr_pkg
`default_nettype none
module eftr_ctrl import eftr_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [1:0]      req_kind,
   output logic                 req_ready,
   input  wire eftr_status_type status,
   output eftr_cmd_type         cmd
);
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_TRIP  = 4'b0100,
      ST_RETRY = 4'b1000
   } eftr_state_type;

   eftr_state_type       state_ff, state_in;
   logic [DRV_IDX_W-1:0] cnt_ff, cnt_in;
   logic                 accept;
   logic                 cnt_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign cnt_last  = (cnt_ff == DRV_IDX_W'(NUM_DRIVERS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.retry_drv  = cnt_ff;
      cmd.retry_last = cnt_last;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  REQ_SAMPLE: begin
                     if (status.sample_ok) begin
                        cmd.capture = 1'b1;
                        state_in    = ST_CONV;
                     end
                  end
                  REQ_TICK: begin
                     cmd.tick = 1'b1;
                     if (status.tick_fire) begin
                        cnt_in   = '0;
                        state_in = ST_RETRY;
                     end
                  end
                  REQ_SCAN: cmd.arm = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_CONV: begin
            cmd.convert = 1'b1;
            state_in    = status.trip_hit ? ST_TRIP : ST_IDLE;
         end
         ST_TRIP: begin
            if (status.out_free) begin
               cmd.load_trip = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_RETRY: begin
            if (status.out_free) begin
               cmd.load_retry = 1'b1;
               if (cnt_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule
`default_nettype wire
